[sv/shpa_pkg.sv]
package shpa_pkg;

  localparam int COEFF_COUNT = 9;
  localparam int NUM_CH      = 3;
  localparam int IDX_W       = 4;
  localparam int SUM_W       = 56;
  localparam int ROW_W       = SUM_W * NUM_CH;
  localparam int VAL_W       = 16;
  localparam int SQ_W        = 32;
  localparam int TERM_W      = 33;
  localparam int CONST_W     = 18;
  localparam int SPROD_W     = TERM_W + CONST_W;
  localparam int BASIS_W     = 28;
  localparam int BPROD_W     = BASIS_W + VAL_W;
  localparam int OUT_W       = 32;

  // basis scaling: constants in q16, basis values in q14
  localparam int CONST_FRAC  = 16;
  localparam int BASIS_FRAC  = 14;

  // 4*pi in q24 and the final divide by count * 2^38
  localparam int K_W         = 28;
  localparam logic [K_W-1:0] FOUR_PI_Q = 28'd210828714;
  localparam int HALF_W      = SUM_W / 2;
  localparam int PPROD_W     = HALF_W + K_W;
  localparam int N_W         = SUM_W + K_W + 1;
  localparam int DIV_SHIFT   = 38;
  localparam int NQ_W        = N_W - DIV_SHIFT;

  localparam logic [CONST_W-1:0] C0 = 18'd18487;
  localparam logic [CONST_W-1:0] C1 = 18'd32021;
  localparam logic [CONST_W-1:0] C2 = 18'd71601;
  localparam logic [CONST_W-1:0] C3 = 18'd20670;
  localparam logic [CONST_W-1:0] C4 = 18'd35801;

  // basis order
  localparam logic [IDX_W-1:0] B_DC   = 4'd0;
  localparam logic [IDX_W-1:0] B_Y    = 4'd1;
  localparam logic [IDX_W-1:0] B_Z    = 4'd2;
  localparam logic [IDX_W-1:0] B_X    = 4'd3;
  localparam logic [IDX_W-1:0] B_XY   = 4'd4;
  localparam logic [IDX_W-1:0] B_YZ   = 4'd5;
  localparam logic [IDX_W-1:0] B_ZZ   = 4'd6;
  localparam logic [IDX_W-1:0] B_XZ   = 4'd7;
  localparam logic [IDX_W-1:0] B_XXYY = 4'd8;
  localparam logic [IDX_W-1:0] B_LAST = B_XXYY;

  typedef struct packed {
    logic signed [VAL_W-1:0] dir_x;
    logic signed [VAL_W-1:0] dir_y;
    logic signed [VAL_W-1:0] dir_z;
    logic signed [VAL_W-1:0] value_ch0;
    logic signed [VAL_W-1:0] value_ch1;
    logic signed [VAL_W-1:0] value_ch2;
    logic                    last_sample;
  } sample_t;

  typedef struct packed {
    logic [IDX_W-1:0]        coeff_index;
    logic signed [OUT_W-1:0] coeff_ch0;
    logic signed [OUT_W-1:0] coeff_ch1;
    logic signed [OUT_W-1:0] coeff_ch2;
    logic                    saturated;
    logic                    last_coeff;
  } coeff_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ACC,
    ST_ORD,
    ST_OMUL,
    ST_OADD,
    ST_ODIV,
    ST_OEMIT
  } shpa_state_t;

endpackage

[sv/sh_order2_projection_accumulator.sv]
// channel   dir  handshake              payload
// sample    in   start / busy           sample (shpa_pkg::sample_t)
// result    out  result_valid strobe    result (shpa_pkg::coeff_t)
//
// a sample transaction is taken when start is high and busy is low
// accumulation of a sample: the squares in ST_PREP, then nine row read-modify-writes
//   through the sum memory, and then the pipeline drains
// a last sample then adds, per coefficient of the nine, a row read, a multiply step, an
//   add step, a bit-serial divide by the sample count and one emit
// reset is synchronous; the sum memory rows are masked to zero by row valid bits
// results show for one cycle each and the receiver cannot stall them
module sh_order2_projection_accumulator #(
  parameter int MAX_SAMPLES_LOG2 = 20,
  parameter int DIR_FRAC_BITS    = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  shpa_pkg::sample_t sample,
  output logic              busy,
  output logic              result_valid,
  output shpa_pkg::coeff_t  result
);

  import shpa_pkg::*;

  localparam int CNT_W  = MAX_SAMPLES_LOG2 + 1;
  localparam int SH0    = CONST_FRAC - BASIS_FRAC;
  localparam int SH1    = CONST_FRAC + DIR_FRAC_BITS - BASIS_FRAC;
  localparam int SH2    = CONST_FRAC + 2 * DIR_FRAC_BITS - BASIS_FRAC;
  localparam int DCNT_W = $clog2(NQ_W);
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(NQ_W - 1);

  shpa_state_t state, state_next;

  // captured sample
  logic signed [VAL_W-1:0] x, y, z;
  logic signed [VAL_W-1:0] v [NUM_CH];
  logic                    last_flag;
  logic signed [SQ_W-1:0]  xx, yy, zz;
  logic [CNT_W-1:0]        sample_count;

  // row valid bits stand in for clearing the sum memory
  logic [COEFF_COUNT-1:0]  row_valid;
  logic                    rd_live;

  // accumulation pipeline
  logic                      iss_act;
  logic [IDX_W-1:0]          iss_k;
  logic                      s1_v, s2_v, s3_v, s4_v;
  logic [IDX_W-1:0]          s1_k, s2_k, s3_k, s4_k;
  logic signed [TERM_W-1:0]  s1_term;
  logic signed [CONST_W-1:0] s1_c;
  logic signed [SPROD_W-1:0] s2_prod;
  logic signed [BASIS_W-1:0] s3_basis;
  logic signed [BPROD_W-1:0] s4_p [NUM_CH];

  // output path
  logic [IDX_W-1:0]        out_k;
  logic [PPROD_W-1:0]      ph [NUM_CH];
  logic [PPROD_W-1:0]      pl [NUM_CH];
  logic                    neg [NUM_CH];
  logic [NQ_W-1:0]         nq [NUM_CH];
  logic [CNT_W-1:0]        rem [NUM_CH];
  logic [DCNT_W-1:0]       div_cnt;

  // memory port
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr, ram_raddr;
  logic [ROW_W-1:0]         ram_wdata, ram_rdata, row_eff;

  // issue stage: one 16x16 multiply per basis term
  logic signed [VAL_W-1:0]  mul_a, mul_b;
  logic signed [SQ_W-1:0]   xprod;
  logic signed [TERM_W-1:0] term;
  logic [CONST_W-1:0]       cnst;

  // rounding stage
  logic [SPROD_W-1:0] mag, r0, r1, r2, rsel;

  // divider and saturation
  logic [CNT_W:0]     trial [NUM_CH];
  logic               ge [NUM_CH];
  logic [CNT_W:0]     diff [NUM_CH];
  logic [OUT_W-1:0]   oval [NUM_CH];
  logic               oclip [NUM_CH];

  shpa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (COEFF_COUNT)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy = (state != ST_IDLE);

  // row never written since the last clear reads as zero
  assign row_eff   = rd_live ? ram_rdata : '0;
  assign ram_raddr = (state == ST_ACC) ? s3_k : out_k;
  assign ram_we    = s4_v;
  assign ram_waddr = s4_k;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      ram_wdata[c*SUM_W +: SUM_W] = row_eff[c*SUM_W +: SUM_W]
                                    + {{(SUM_W-BPROD_W){s4_p[c][BPROD_W-1]}}, s4_p[c]};
    end
  end

  // term selection for the basis being issued
  always_comb begin
    mul_a = x;
    mul_b = y;
    case (iss_k)
      B_YZ:    begin mul_a = y; mul_b = z; end
      B_XZ:    begin mul_a = x; mul_b = z; end
      default: begin mul_a = x; mul_b = y; end
    endcase
    xprod = mul_a * mul_b;
    term  = '0;
    cnst  = C0;
    unique case (iss_k)
      B_DC:    begin term = TERM_W'(1);              cnst = C0; end
      B_Y:     begin term = -TERM_W'(y);             cnst = C1; end
      B_Z:     begin term = TERM_W'(z);              cnst = C1; end
      B_X:     begin term = -TERM_W'(x);             cnst = C1; end
      B_XY:    begin term = TERM_W'(xprod);          cnst = C2; end
      B_YZ:    begin term = -TERM_W'(xprod);         cnst = C2; end
      B_ZZ:    begin
        term = (TERM_W'(zz) <<< 1) - TERM_W'(xx) - TERM_W'(yy);
        cnst = C3;
      end
      B_XZ:    begin term = -TERM_W'(xprod);         cnst = C2; end
      B_XXYY:  begin term = TERM_W'(xx) - TERM_W'(yy); cnst = C4; end
      default: begin term = '0;                      cnst = C0; end
    endcase
  end

  // round half away from zero at the shift that belongs to the band
  always_comb begin
    mag  = s2_prod[SPROD_W-1] ? SPROD_W'(-s2_prod) : SPROD_W'(s2_prod);
    r0   = (mag + (SPROD_W'(1) << (SH0 - 1))) >> SH0;
    r1   = (mag + (SPROD_W'(1) << (SH1 - 1))) >> SH1;
    r2   = (mag + (SPROD_W'(1) << (SH2 - 1))) >> SH2;
    if (s2_k == B_DC) begin
      rsel = r0;
    end else if (s2_k <= B_X) begin
      rsel = r1;
    end else begin
      rsel = r2;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      trial[c] = {rem[c], nq[c][NQ_W-1]};
      ge[c]    = (trial[c] >= {1'b0, sample_count});
      diff[c]  = trial[c] - {1'b0, sample_count};
      if (!neg[c]) begin
        oclip[c] = (nq[c][NQ_W-1:OUT_W-1] != '0);
        oval[c]  = oclip[c] ? {1'b0, {(OUT_W-1){1'b1}}} : nq[c][OUT_W-1:0];
      end else begin
        oclip[c] = (nq[c][NQ_W-1:OUT_W] != '0)
                   || (nq[c][OUT_W-1] && (nq[c][OUT_W-2:0] != '0));
        oval[c]  = oclip[c] ? {1'b1, {(OUT_W-1){1'b0}}} : -nq[c][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_PREP;
      ST_PREP:  state_next = ST_ACC;
      ST_ACC:   begin
        if (s4_v && s4_k == B_LAST) begin
          state_next = last_flag ? ST_ORD : ST_IDLE;
        end
      end
      ST_ORD:   state_next = ST_OMUL;
      ST_OMUL:  state_next = ST_OADD;
      ST_OADD:  state_next = ST_ODIV;
      ST_ODIV:  if (div_cnt == DIV_LAST) state_next = ST_OEMIT;
      ST_OEMIT: state_next = (out_k == B_LAST) ? ST_IDLE : ST_ORD;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid    <= '0;
      sample_count <= '0;
      iss_act      <= 1'b0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3_v         <= 1'b0;
      s4_v         <= 1'b0;
      result_valid <= 1'b0;
      out_k        <= '0;
      div_cnt      <= '0;
    end else begin
      result_valid <= 1'b0;
      rd_live      <= row_valid[ram_raddr];

      if (state == ST_IDLE && start) begin
        x         <= sample.dir_x;
        y         <= sample.dir_y;
        z         <= sample.dir_z;
        v[0]      <= sample.value_ch0;
        v[1]      <= sample.value_ch1;
        v[2]      <= sample.value_ch2;
        last_flag <= sample.last_sample;
      end

      if (state == ST_PREP) begin
        xx      <= x * x;
        yy      <= y * y;
        zz      <= z * z;
        iss_k   <= B_DC;
        iss_act <= 1'b1;
        if (sample_count != CNT_MAX) begin
          sample_count <= sample_count + 1'b1;
        end
      end

      // issue one basis per cycle
      s1_v <= iss_act;
      if (iss_act) begin
        s1_k    <= iss_k;
        s1_term <= term;
        s1_c    <= $signed(cnst);
        if (iss_k == B_LAST) begin
          iss_act <= 1'b0;
        end else begin
          iss_k <= iss_k + 1'b1;
        end
      end

      s2_v     <= s1_v;
      s2_k     <= s1_k;
      s2_prod  <= s1_term * s1_c;

      s3_v     <= s2_v;
      s3_k     <= s2_k;
      s3_basis <= s2_prod[SPROD_W-1] ? -BASIS_W'(rsel) : BASIS_W'(rsel);

      s4_v     <= s3_v;
      s4_k     <= s3_k;
      for (int c = 0; c < NUM_CH; c++) begin
        s4_p[c] <= s3_basis * v[c];
      end

      if (s4_v) begin
        row_valid[s4_k] <= 1'b1;
      end

      if (state == ST_ACC) begin
        out_k <= B_DC;
      end

      // scale: |sum| * 4pi in two half products
      if (state == ST_OMUL) begin
        for (int c = 0; c < NUM_CH; c++) begin
          logic [SUM_W-1:0] u, m;
          u      = row_eff[c*SUM_W +: SUM_W];
          m      = u[SUM_W-1] ? -u : u;
          neg[c] <= u[SUM_W-1];
          ph[c]  <= m[SUM_W-1:HALF_W] * FOUR_PI_Q;
          pl[c]  <= m[HALF_W-1:0] * FOUR_PI_Q;
        end
      end

      // add half the divisor, drop the fixed 2^38 part of it
      if (state == ST_OADD) begin
        for (int c = 0; c < NUM_CH; c++) begin
          logic [N_W-1:0] n;
          n      = (N_W'(ph[c]) << HALF_W) + N_W'(pl[c])
                   + (N_W'(sample_count) << (DIV_SHIFT - 1));
          nq[c]  <= n[N_W-1:DIV_SHIFT];
          rem[c] <= '0;
        end
        div_cnt <= '0;
      end

      // restoring divide by the sample count, one quotient bit per cycle
      if (state == ST_ODIV) begin
        for (int c = 0; c < NUM_CH; c++) begin
          rem[c] <= ge[c] ? diff[c][CNT_W-1:0] : trial[c][CNT_W-1:0];
          nq[c]  <= {nq[c][NQ_W-2:0], ge[c]};
        end
        div_cnt <= div_cnt + 1'b1;
      end

      if (state == ST_OEMIT) begin
        result_valid       <= 1'b1;
        result.coeff_index <= out_k;
        result.coeff_ch0   <= oval[0];
        result.coeff_ch1   <= oval[1];
        result.coeff_ch2   <= oval[2];
        result.saturated   <= oclip[0] | oclip[1] | oclip[2];
        result.last_coeff  <= (out_k == B_LAST);
        if (out_k == B_LAST) begin
          row_valid    <= '0;
          sample_count <= '0;
        end else begin
          out_k <= out_k + 1'b1;
        end
      end
    end
  end

  // no result while a sample is being accumulated
  a_no_result_in_acc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PREP || state == ST_ACC) |-> !result_valid)
    else $error("result during accumulation");

  // the sum memory is only written by the accumulate pipeline
  a_write_in_acc: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_ACC))
    else $error("sum write outside accumulation");

  // the run is cleared when its final coefficient goes out
  a_cleared_at_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_coeff) |-> (row_valid == '0 && sample_count == '0))
    else $error("state not cleared after last coefficient");

  // the divisor is never zero
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OADD || state == ST_ODIV) |-> (sample_count != '0))
    else $error("zero sample count in scaling");

endmodule

[sv/shpa_ram.sv]
module shpa_ram #(
  parameter int WIDTH = 168,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sim/sh_order2_projection_checker.sv]
`timescale 1ns / 100ps

module sh_order2_projection_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  shpa_pkg::sample_t sample,
  input  logic              result_valid,
  input  shpa_pkg::coeff_t  result,
  output int                fail_count,
  output int                pending
);
  import shpa_pkg::*;

  localparam int CNT_W = 21;

  logic signed [55:0] sums [27];
  logic [CNT_W-1:0]   count;
  coeff_t             coeff_queue [$];

  assign pending = coeff_queue.size();

  function automatic longint round_shift(longint v, longint c, int s);
    longint p;
    longint m;
    longint r;
    p = v * c;
    m = (p < 0) ? -p : p;
    r = (m + (longint'(1) << (s - 1))) >>> s;
    return (p < 0) ? -r : r;
  endfunction

  // magnitude * 4pi / (count * 2^38), rounded half away, clipped to 32 bits
  function automatic logic [31:0] scale_coeff(logic signed [55:0] s, logic [CNT_W-1:0] n,
                                              inout logic clip);
    logic          neg;
    logic [55:0]   m;
    logic [127:0]  num;
    logic [127:0]  den;
    logic [127:0]  q;
    neg = s[55];
    m = neg ? -s : s;
    den = 128'(n) << 38;
    num = 128'(m) * 128'(FOUR_PI_Q) + (den >> 1);
    q = num / den;
    if (!neg && q > 128'h7FFFFFFF) begin
      q = 128'h7FFFFFFF;
      clip = 1'b1;
    end else if (neg && q > 128'h80000000) begin
      q = 128'h80000000;
      clip = 1'b1;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  task automatic project_sample(sample_t smp);
    longint x, y, z, xx, yy, zz;
    longint b [9];
    longint v [3];
    coeff_t c;
    logic clip;
    x = smp.dir_x; y = smp.dir_y; z = smp.dir_z;
    xx = x * x; yy = y * y; zz = z * z;
    b[0] = round_shift(1, C0, 2);
    b[1] = round_shift(-y, C1, 16);
    b[2] = round_shift(z, C1, 16);
    b[3] = round_shift(-x, C1, 16);
    b[4] = round_shift(x * y, C2, 30);
    b[5] = round_shift(-(y * z), C2, 30);
    b[6] = round_shift(2 * zz - xx - yy, C3, 30);
    b[7] = round_shift(-(x * z), C2, 30);
    b[8] = round_shift(xx - yy, C4, 30);
    v[0] = smp.value_ch0; v[1] = smp.value_ch1; v[2] = smp.value_ch2;
    for (int k = 0; k < 9; k++)
      for (int ch = 0; ch < 3; ch++)
        sums[k*3+ch] = sums[k*3+ch] + 56'(b[k] * v[ch]);
    if (count != '1) count = count + 1'b1;
    if (smp.last_sample) begin
      for (int k = 0; k < 9; k++) begin
        clip = 1'b0;
        c.coeff_index = IDX_W'(k);
        c.coeff_ch0 = scale_coeff(sums[k*3], count, clip);
        c.coeff_ch1 = scale_coeff(sums[k*3+1], count, clip);
        c.coeff_ch2 = scale_coeff(sums[k*3+2], count, clip);
        c.saturated = clip;
        c.last_coeff = (IDX_W'(k) == B_LAST);
        coeff_queue = {coeff_queue, c};
      end
      foreach (sums[i]) sums[i] = '0;
      count = '0;
    end
  endtask

  always @(posedge clk) begin
    coeff_t e;
    if (rst) begin
      foreach (sums[i]) sums[i] <= '0;
      count <= '0;
      coeff_queue.delete();
      fail_count <= 0;
    end else begin
      if (start && !busy) project_sample(sample);
      if (result_valid) begin
        if (coeff_queue.size() == 0) begin
          $error("unexpected coefficient transaction index %0d", result.coeff_index);
          fail_count <= fail_count + 1;
        end else begin
          e = coeff_queue.pop_front();
          if (e != result) begin
            fail_count <= fail_count + 1;
            if (e.coeff_index != result.coeff_index)
              $error("coeff_index exp %0d got %0d", e.coeff_index, result.coeff_index);
            if (e.coeff_ch0 != result.coeff_ch0)
              $error("coeff_ch0 exp %0d got %0d", e.coeff_ch0, result.coeff_ch0);
            if (e.coeff_ch1 != result.coeff_ch1)
              $error("coeff_ch1 exp %0d got %0d", e.coeff_ch1, result.coeff_ch1);
            if (e.coeff_ch2 != result.coeff_ch2)
              $error("coeff_ch2 exp %0d got %0d", e.coeff_ch2, result.coeff_ch2);
            if (e.saturated != result.saturated)
              $error("saturated exp %0d got %0d", e.saturated, result.saturated);
            if (e.last_coeff != result.last_coeff)
              $error("last_coeff exp %0d got %0d", e.last_coeff, result.last_coeff);
          end
        end
      end
    end
  end

endmodule

[sim/sh_order2_projection_accumulator_tb.sv]
`timescale 1ns / 100ps

module sh_order2_projection_accumulator_tb;
  import shpa_pkg::*;

  // after a last sample the block still emits nine coefficients
  localparam int DRAIN_CYCLES = 600;
  localparam int STALL_LIMIT  = 5000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  sample_t sample = '0;
  logic    busy;
  logic    result_valid;
  coeff_t  result;
  int      fail_count;
  int      pending;
  int      idle_pct = 0;
  int      stall_cycles = 0;

  sh_order2_projection_accumulator uut (
    .clk(clk), .rst(rst), .start(start), .sample(sample),
    .busy(busy), .result_valid(result_valid), .result(result)
  );

  sh_order2_projection_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .result_valid(result_valid), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog: cycles without any accepted transaction
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);               // out of range, used as given
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // one sample transaction; start stays high across back-to-back samples
  task automatic send_sample(sample_t s);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_dir(int x, int y, int z, int v0, int v1, int v2, bit last);
    sample_t s;
    s.dir_x = 16'(x); s.dir_y = 16'(y); s.dir_z = 16'(z);
    s.value_ch0 = 16'(v0); s.value_ch1 = 16'(v1); s.value_ch2 = 16'(v2);
    s.last_sample = last;
    send_sample(s);
  endtask

  task automatic send_random_run(int len, bit scalar);
    sample_t s;
    for (int i = 0; i < len; i++) begin
      s.dir_x = rand_dir(); s.dir_y = rand_dir(); s.dir_z = rand_dir();
      s.value_ch0 = rand_value();
      s.value_ch1 = scalar ? 16'sd0 : rand_value();
      s.value_ch2 = scalar ? 16'sd0 : rand_value();
      s.last_sample = (i == len - 1);
      send_sample(s);
    end
  endtask

  initial begin
    int left;
    int len;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: axes, extremes, single-sample runs, a six-sample run of extreme values
    send_dir(16384, 0, 0, 32767, -32768, 1, 1'b1);
    send_dir(0, 16384, 0, -32768, 32767, -1, 1'b1);
    send_dir(0, 0, 16384, 32767, 32767, 32767, 1'b1);
    send_dir(-16384, -16384, -16384, -32768, -32768, -32768, 1'b1);
    send_dir(-32768, 32767, -32768, 32767, -32768, 0, 1'b1);
    send_dir(11585, 11585, 0, 1000, 0, 0, 1'b0);
    send_dir(0, -11585, 11585, -1000, 0, 0, 1'b0);
    send_dir(9459, 9459, 9459, 12345, 0, 0, 1'b1);
    send_dir(0, 0, 0, 0, 0, 0, 1'b1);
    for (int i = 0; i < 6; i++)
      send_dir(32767, -32768, 32767, 32767, -32768, 32767, i == 5);

    // random runs in idling phases; mostly short runs, a few long ones
    left = 440;
    for (int ph = 0; left > 0; ph++) begin
      idle_pct = (ph % 4 == 1) ? 84 : (ph % 4 == 3) ? 12 : 0;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (len > left) len = left;
      send_random_run(len, $urandom_range(0, 3) == 0);
      left -= len;
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
sv/shpa_pkg.sv
sv/shpa_ram.sv
sv/sh_order2_projection_accumulator.sv
sim/sh_order2_projection_checker.sv
sim/sh_order2_projection_accumulator_tb.sv
